// File: design/npl_pkg.sv
// Shared constants and types for the nearest point lookup block.
`timescale 1ns / 1ps
`default_nettype none

package npl_pkg;

    // Table size and coordinate width actually compared
    localparam int MAX_POINTS = 1024;
    localparam int COORD_W    = 32;
    localparam int AXES       = 3;
    localparam int FIELD_W    = 32;
    localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int SCAN_W     = $clog2(MAX_POINTS + 1);
    // Three exact squares of (COORD_W)-bit magnitudes
    localparam int SUM_W      = 2 * COORD_W + 2;

    localparam int CNT_REG_W  = 11;
    localparam int DIM_REG_W  = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic REG_POINT_COUNT = 1'b0;
    localparam logic REG_POINT_DIM   = 1'b1;

    typedef logic [AXES-1:0][COORD_W-1:0] t_npl_coords;

    typedef struct packed {
        logic                      command;
        logic [9:0]                entry_index;
        logic signed [FIELD_W-1:0] coord_x;
        logic signed [FIELD_W-1:0] coord_y;
        logic signed [FIELD_W-1:0] coord_z;
        logic signed [FIELD_W-1:0] entry_value;
        logic [1:0]                query_dims;
    } t_npl_in;

    typedef struct packed {
        logic [9:0]                nearest_index;
        logic signed [FIELD_W-1:0] nearest_value;
        logic                      table_empty;
    } t_npl_out;

    // One table entry travelling down the distance chain
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [ADDR_W-1:0] idx;
        logic [SUM_W-1:0]  sum;
        t_npl_coords       coord;
    } t_npl_flow;

    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] idx;
    } t_npl_best;

endpackage

`default_nettype wire

// File: design/npl_cell.sv
// One distance cell: adds the squared difference on its axis to the passing sum.
`timescale 1ns / 1ps
`default_nettype none

module npl_cell (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire npl_pkg::t_npl_flow         i_flow,
    input  wire [npl_pkg::COORD_W-1:0]      i_query,
    input  wire                             i_enable,
    output npl_pkg::t_npl_flow              o_flow
);

    npl_pkg::t_npl_flow                   r_s1, n_s1;
    npl_pkg::t_npl_flow                   r_s2;
    npl_pkg::t_npl_flow                   r_s3, n_s3;
    logic [npl_pkg::COORD_W-1:0]          r_abs, n_abs;
    logic [2*npl_pkg::COORD_W-1:0]        r_square;
    logic signed [npl_pkg::COORD_W:0]     w_diff;

    // Stage one: absolute difference; consume the head coordinate, shift the rest down
    always_comb begin
        w_diff = $signed({i_query[npl_pkg::COORD_W-1], i_query})
               - $signed({i_flow.coord[0][npl_pkg::COORD_W-1], i_flow.coord[0]});
        n_abs  = w_diff[npl_pkg::COORD_W] ? npl_pkg::COORD_W'(-w_diff)
                                          : npl_pkg::COORD_W'(w_diff);
        n_s1       = i_flow;
        n_s1.coord = {npl_pkg::COORD_W'(0), i_flow.coord[npl_pkg::AXES-1:1]};
    end

    // Stage three: accumulate when this axis takes part
    always_comb begin
        n_s3     = r_s2;
        n_s3.sum = r_s2.sum + (i_enable ? npl_pkg::SUM_W'(r_square) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
        end else begin
            r_s1 <= n_s1;
            r_s2 <= r_s1;
            r_s3 <= n_s3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_abs    <= n_abs;
        r_square <= r_abs * r_abs;
    end

    assign o_flow = r_s3;

endmodule

`default_nettype wire

// File: design/npl_best.sv
// Running minimum over the distances leaving the cell chain.
`timescale 1ns / 1ps
`default_nettype none

module npl_best (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire npl_pkg::t_npl_flow  i_flow,
    output npl_pkg::t_npl_best       o_best
);

    logic [npl_pkg::SUM_W-1:0]  r_best_sum;
    logic [npl_pkg::ADDR_W-1:0] r_best_idx;
    logic                       r_done;
    logic                       w_take;

    // Entry zero opens a scan; strict less keeps the earlier index on ties
    assign w_take = i_flow.valid && ((i_flow.idx == '0) || (i_flow.sum < r_best_sum));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_flow.valid && i_flow.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_best_sum <= i_flow.sum;
            r_best_idx <= i_flow.idx;
        end
    end

    assign o_best.done = r_done;
    assign o_best.idx  = r_best_idx;

endmodule

`default_nettype wire

// File: design/nearest_point_lookup.sv
// Top level of the nearest point lookup: table memory, scan control, cell chain, output.
// Load: one transfer per cycle, no result. Query: items stall until the result is registered,
// the next item is taken as the result turns valid; the scan uses the one-entry-per-cycle
// table read port and a 9-stage three-cell distance chain. An empty table skips the scan.
// Reset clears control and config (point_count 0, point_dimension 3); table contents stay
// undefined until loaded, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module nearest_point_lookup (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // item channel
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire npl_pkg::t_npl_in              i_in_data,
    // result channel
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output npl_pkg::t_npl_out                  o_out_data,
    // configuration
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [npl_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire  [npl_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [npl_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_VALUE = 5'b01000,
        S_PUT   = 5'b10000
    } t_state;

    t_state                               r_state, n_state;

    // configuration registers
    logic [npl_pkg::CNT_REG_W-1:0]        r_point_count;
    logic [npl_pkg::DIM_REG_W-1:0]        r_point_dim;

    // table memories: coordinates are read by the scan, values once per query
    npl_pkg::t_npl_coords                 r_point_mem [npl_pkg::MAX_POINTS];
    logic [npl_pkg::FIELD_W-1:0]          r_value_mem [npl_pkg::MAX_POINTS];
    npl_pkg::t_npl_coords                 r_pt_rd;
    logic [npl_pkg::FIELD_W-1:0]          r_value_rd;

    // query held for the whole scan
    logic [npl_pkg::COORD_W-1:0]          r_query [npl_pkg::AXES];
    logic [npl_pkg::AXES-1:0]             r_axis_en;
    logic [npl_pkg::SCAN_W-1:0]           r_count;
    logic [npl_pkg::SCAN_W-1:0]           r_issue;
    logic                                 r_empty;

    // read-side control aligned with r_pt_rd
    logic                                 r_rd_valid;
    logic                                 r_rd_last;
    logic [npl_pkg::ADDR_W-1:0]           r_rd_idx;

    // output register
    logic                                 r_out_valid;
    npl_pkg::t_npl_out                    r_out_data;

    npl_pkg::t_npl_flow                   w_flow [npl_pkg::AXES+1];
    npl_pkg::t_npl_best                   w_best;
    npl_pkg::t_npl_coords                 w_coords;

    logic                                 w_in_xfer;
    logic                                 w_load;
    logic                                 w_query;
    logic                                 w_cfg_wr;
    logic                                 w_issue_last;
    logic                                 w_out_free;
    logic [1:0]                           w_axes;
    logic [npl_pkg::SCAN_W-1:0]           w_count;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign w_load     = w_in_xfer && (i_in_data.command == npl_pkg::CMD_LOAD);
    assign w_query    = w_in_xfer && (i_in_data.command == npl_pkg::CMD_QUERY);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // ------------------------------------------------------------------
    // Configuration port: no wait states (pready tied high), write on the access phase
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[2])
            npl_pkg::REG_POINT_COUNT: prdata = npl_pkg::APB_DATA_W'(r_point_count);
            npl_pkg::REG_POINT_DIM:   prdata = npl_pkg::APB_DATA_W'(r_point_dim);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
            r_point_dim   <= npl_pkg::DIM_REG_W'(3);
        end else if (w_cfg_wr) begin
            case (paddr[2])
                npl_pkg::REG_POINT_COUNT: r_point_count <= pwdata[npl_pkg::CNT_REG_W-1:0];
                npl_pkg::REG_POINT_DIM:   r_point_dim   <= pwdata[npl_pkg::DIM_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Query set-up: clamp the scan length and pick the compared axes
    // ------------------------------------------------------------------
    always_comb begin
        w_axes  = (i_in_data.query_dims < r_point_dim) ? i_in_data.query_dims : r_point_dim;
        w_count = (32'(r_point_count) > 32'(npl_pkg::MAX_POINTS))
                ? npl_pkg::SCAN_W'(npl_pkg::MAX_POINTS)
                : npl_pkg::SCAN_W'(r_point_count);
        w_coords[0] = i_in_data.coord_x[npl_pkg::COORD_W-1:0];
        w_coords[1] = i_in_data.coord_y[npl_pkg::COORD_W-1:0];
        w_coords[2] = i_in_data.coord_z[npl_pkg::COORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            for (int k = 0; k < npl_pkg::AXES; k++) begin
                r_query[k]   <= w_coords[k];
                r_axis_en[k] <= (2'(k) < w_axes);
            end
            r_count <= w_count;
            r_empty <= (w_count == '0);
        end
    end

    // ------------------------------------------------------------------
    // Scan control
    // ------------------------------------------------------------------
    assign w_issue_last = (r_issue == npl_pkg::SCAN_W'(r_count - 1'b1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_query) begin
                    // an empty table skips the scan altogether
                    n_state = (w_count == '0) ? S_PUT : S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_issue_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_best.done) begin
                    n_state = S_VALUE;
                end
            end
            S_VALUE: begin
                n_state = S_PUT;
            end
            S_PUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_issue    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= (r_state == S_SCAN);
            // advance one entry per cycle during the scan, rewind otherwise
            if (r_state == S_SCAN) begin
                r_issue <= r_issue + 1'b1;
            end else begin
                r_issue <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_last <= w_issue_last;
        r_rd_idx  <= r_issue[npl_pkg::ADDR_W-1:0];
    end

    // ------------------------------------------------------------------
    // Table memories
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_load && (32'(i_in_data.entry_index) < 32'(npl_pkg::MAX_POINTS))) begin
            r_point_mem[npl_pkg::ADDR_W'(i_in_data.entry_index)] <= w_coords;
        end
        r_pt_rd <= r_point_mem[r_issue[npl_pkg::ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_load && (32'(i_in_data.entry_index) < 32'(npl_pkg::MAX_POINTS))) begin
            r_value_mem[npl_pkg::ADDR_W'(i_in_data.entry_index)] <= i_in_data.entry_value;
        end
        r_value_rd <= r_value_mem[w_best.idx];
    end

    // ------------------------------------------------------------------
    // Distance chain: one cell per axis, entries stream through every cycle
    // ------------------------------------------------------------------
    always_comb begin
        w_flow[0].valid = r_rd_valid;
        w_flow[0].last  = r_rd_last;
        w_flow[0].idx   = r_rd_idx;
        w_flow[0].sum   = '0;
        w_flow[0].coord = r_pt_rd;
    end

    for (genvar g = 0; g < npl_pkg::AXES; g++) begin : g_cell
        npl_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_flow   (w_flow[g]),
            .i_query  (r_query[g]),
            .i_enable (r_axis_en[g]),
            .o_flow   (w_flow[g+1])
        );
    end

    npl_best u_best (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flow  (w_flow[npl_pkg::AXES]),
        .o_best  (w_best)
    );

    // ------------------------------------------------------------------
    // Output register: hold the result until the transfer completes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_PUT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_PUT) && w_out_free) begin
            r_out_data.table_empty   <= r_empty;
            r_out_data.nearest_index <= r_empty ? 10'd0 : 10'(w_best.idx);
            r_out_data.nearest_value <= r_empty ? '0 : r_value_rd;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_best.done |-> (r_state == S_DRAIN))
        else $error("scan finished outside the drain phase");

    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_issue < r_count))
        else $error("scan read past the entry count");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_rd_valid && !w_flow[npl_pkg::AXES].valid)
        else $error("entries still in flight while accepting items");

    a_out_from_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_PUT))
        else $error("result raised outside the put phase");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.table_empty) |->
            (r_out_data.nearest_index == '0) && (r_out_data.nearest_value == '0))
        else $error("empty-table result carries a non-zero index or value");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking testbench for the nearest point lookup block.
`timescale 1ns / 1ps

module tb_top;
    import npl_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    // Quiet cycles after the last result, and before a register write following loads
    localparam int SETTLE      = 40;
    localparam int CFG_GUARD   = 20;

    // One row of the directed script: either a register write or an item
    typedef struct {
        bit          is_cfg;
        logic        cfg_reg;
        logic [31:0] cfg_val;
        t_npl_in     item;
        bit          typed;
        t_npl_out    answer;
    } t_step;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_npl_in     in_data   = '0;
    logic        out_stall = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr  = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;

    wire                   in_stall;
    wire                   out_valid;
    t_npl_out              out_data;
    wire [APB_DATA_W-1:0]  prdata;
    wire                   pready;

    nearest_point_lookup i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow of the block: point table, registers and the answers owed
    // ------------------------------------------------------------------
    logic [31:0] pt_coord  [MAX_POINTS][3];
    logic [31:0] pt_value  [MAX_POINTS];
    bit          pt_loaded [MAX_POINTS];
    logic [10:0] cfg_count = 11'd0;
    logic [1:0]  cfg_dims  = 2'd3;

    t_npl_out    hits_due[$];
    int          mismatches  = 0;
    int          taken       = 0;
    int          cycles      = 0;
    bit          sender_calm = 1'b0;

    // Entries that a query actually visits
    function automatic int scan_n();
        return (cfg_count > MAX_POINTS) ? MAX_POINTS : int'(cfg_count);
    endfunction

    // Brute-force search: exact sums of squares, first minimum wins
    function automatic t_npl_out nearest_of(t_npl_in q);
        t_npl_out    r;
        logic [31:0] qc [3];
        logic [66:0] span_sq;
        logic [66:0] best;
        logic [66:0] mag;
        longint      dl;
        int          n_axes;
        bit          found;
        qc[0]  = q.coord_x;
        qc[1]  = q.coord_y;
        qc[2]  = q.coord_z;
        n_axes = (q.query_dims < cfg_dims) ? int'(q.query_dims) : int'(cfg_dims);
        r      = '0;
        r.table_empty = 1'b1;
        found  = 1'b0;
        best   = '0;
        for (int p = 0; p < scan_n(); p++) begin
            span_sq = '0;
            for (int a = 0; a < n_axes; a++) begin
                dl = longint'($signed(qc[a])) - longint'($signed(pt_coord[p][a]));
                if (dl < 0) begin
                    dl = -dl;
                end
                mag     = 67'(dl);
                span_sq = span_sq + mag * mag;
            end
            // strict compare keeps the earlier index on a tie
            if (!found || span_sq < best) begin
                found           = 1'b1;
                best            = span_sq;
                r.nearest_index = 10'(p);
                r.nearest_value = pt_value[p];
                r.table_empty   = 1'b0;
            end
        end
        return r;
    endfunction

    // Queries may only visit entries that have been loaded
    function automatic bit scan_ready();
        for (int p = 0; p < scan_n(); p++) begin
            if (!pt_loaded[p]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Random content
    // ------------------------------------------------------------------
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4, 5:    return $urandom;
            default: return 32'($urandom_range(262143)) - 32'd131072;
        endcase
    endfunction

    function automatic logic [31:0] jitter();
        return 32'($urandom_range(4095)) - 32'd2048;
    endfunction

    function automatic t_npl_in rand_load(int slot);
        t_npl_in it;
        int      twin;
        it.command     = CMD_LOAD;
        it.entry_index = 10'(slot);
        it.coord_x     = pick_coord();
        it.coord_y     = pick_coord();
        it.coord_z     = pick_coord();
        it.entry_value = $urandom;
        it.query_dims  = 2'($urandom_range(3));
        // copy another point now and then to provoke ties
        twin = $urandom_range(63);
        if ($urandom_range(3) == 0 && pt_loaded[twin]) begin
            it.coord_x = pt_coord[twin][0];
            it.coord_y = pt_coord[twin][1];
            it.coord_z = pt_coord[twin][2];
        end
        return it;
    endfunction

    function automatic int pick_slot();
        if ($urandom_range(3) == 0 || scan_n() == 0) begin
            return $urandom_range(MAX_POINTS - 1);
        end
        return $urandom_range(scan_n() - 1);
    endfunction

    function automatic t_npl_in rand_query();
        t_npl_in it;
        int      base;
        it.command     = CMD_QUERY;
        it.entry_index = 10'($urandom);
        it.entry_value = $urandom;
        it.query_dims  = ($urandom_range(9) < 6) ? 2'd3 : 2'($urandom_range(2));
        if (scan_n() > 0 && $urandom_range(1) == 1) begin
            // land close to a stored point so that the winner is not trivial
            base       = $urandom_range(scan_n() - 1);
            it.coord_x = pt_coord[base][0] + jitter();
            it.coord_y = pt_coord[base][1] + jitter();
            it.coord_z = pt_coord[base][2] + jitter();
        end else begin
            it.coord_x = pick_coord();
            it.coord_y = pick_coord();
            it.coord_z = pick_coord();
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Directed script rows
    // ------------------------------------------------------------------
    function automatic t_step row_load(int slot, logic [31:0] x, logic [31:0] y,
                                       logic [31:0] z, logic [31:0] v);
        t_step s;
        s         = '{default: '0};
        s.item    = '{command: CMD_LOAD, entry_index: 10'(slot), coord_x: x, coord_y: y,
                      coord_z: z, entry_value: v, query_dims: 2'd0};
        return s;
    endfunction

    function automatic t_step row_query(logic [1:0] qd, logic [31:0] x, logic [31:0] y,
                                        logic [31:0] z);
        t_step s;
        s         = '{default: '0};
        s.item    = '{command: CMD_QUERY, entry_index: 10'd0, coord_x: x, coord_y: y,
                      coord_z: z, entry_value: 32'd0, query_dims: qd};
        return s;
    endfunction

    function automatic t_step row_cfg(logic reg_sel, logic [31:0] val);
        t_step s;
        s         = '{default: '0};
        s.is_cfg  = 1'b1;
        s.cfg_reg = reg_sel;
        s.cfg_val = val;
        return s;
    endfunction

    function automatic t_step with_answer(t_step s, int idx, logic [31:0] val, bit empty);
        s.typed  = 1'b1;
        s.answer = '{nearest_index: 10'(idx), nearest_value: val, table_empty: empty};
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Item channel and register port
    // ------------------------------------------------------------------
    // Enter and leave at a falling edge; valid is left high for the caller to reuse
    task automatic send_item(input t_npl_in it, input bit typed, input t_npl_out answer);
        while (!sender_calm && $urandom_range(99) < 8) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        // transfer taken: update the shadow
        if (it.command == CMD_LOAD) begin
            pt_coord[it.entry_index][0] = it.coord_x;
            pt_coord[it.entry_index][1] = it.coord_y;
            pt_coord[it.entry_index][2] = it.coord_z;
            pt_value[it.entry_index]    = it.entry_value;
            pt_loaded[it.entry_index]   = 1'b1;
        end else begin
            hits_due.push_back(typed ? answer : nearest_of(it));
        end
        @(negedge clk);
    endtask

    // Drain the block, then write one register with a setup and an access cycle
    task automatic cfg_write(input logic reg_sel, input logic [31:0] val);
        in_valid <= 1'b0;
        while (hits_due.size() != 0) begin
            @(negedge clk);
        end
        // loads give no result, so allow them to settle
        repeat (CFG_GUARD) @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) begin
            @(posedge clk);
        end
        if (reg_sel == REG_POINT_COUNT) begin
            cfg_count = val[10:0];
        end else begin
            cfg_dims = val[1:0];
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic flag(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch at cycle %0d: %s", cycles, msg);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall, one long hold-off, a calm stretch
    // ------------------------------------------------------------------
    initial begin : result_side
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(negedge clk);
            // hold off once, long enough for the block to back up into its input
            if (!held && taken >= 60) begin
                held      = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (taken >= 150 && taken < 250) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(99) < 8);
            end
        end
    end

    // Compare every transfer on the result channel with the oldest answer owed
    always @(posedge clk) begin : result_check
        t_npl_out want;
        if (rst_n && out_valid && !out_stall) begin
            taken++;
            if (hits_due.size() == 0) begin
                flag($sformatf("result with nothing owed: %p", out_data));
            end else begin
                want = hits_due.pop_front();
                if (out_data.nearest_index !== want.nearest_index) begin
                    flag($sformatf("nearest_index want %0d got %0d",
                                   want.nearest_index, out_data.nearest_index));
                end
                if (out_data.nearest_value !== want.nearest_value) begin
                    flag($sformatf("nearest_value want %h got %h",
                                   want.nearest_value, out_data.nearest_value));
                end
                if (out_data.table_empty !== want.table_empty) begin
                    flag($sformatf("table_empty want %b got %b",
                                   want.table_empty, out_data.table_empty));
                end
            end
        end
    end

    // Watchdog: abandon the run if it hangs
    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_step       script[$];
        int          sent_random;
        int          cnt_list [10];
        logic [1:0]  dim_list [10];

        cnt_list    = '{1, 3, 7, 16, 33, 64, 2, 50, 12, 25};
        dim_list    = '{2'd3, 2'd2, 2'd1, 2'd3, 2'd0, 2'd3, 2'd2, 2'd3, 2'd1, 2'd3};
        sent_random = 0;

        // Hold reset, then release it on a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty table straight after reset
        script.push_back(with_answer(row_query(2'd3, 32'd1, 32'd2, 32'd3), 0, 32'd0, 1'b1));
        // Corner points, a tied pair at the origin, and the top slot
        script.push_back(row_load(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  32'h7FFF_FFFF));
        script.push_back(row_load(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000));
        script.push_back(row_load(2, 32'd0, 32'd0, 32'd0, 32'h1234_5678));
        script.push_back(row_load(3, 32'd0, 32'd0, 32'd0, 32'hCAFE_F00D));
        script.push_back(row_load(MAX_POINTS - 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF, 32'h0000_FFFF));
        script.push_back(row_cfg(REG_POINT_COUNT, 32'd4));
        script.push_back(with_answer(row_query(2'd3, 32'h8000_0000, 32'h8000_0000,
                                               32'h8000_0000), 1, 32'h8000_0000, 1'b0));
        script.push_back(with_answer(row_query(2'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                               32'h7FFF_FFFF), 0, 32'h7FFF_FFFF, 1'b0));
        // exact tie: the lower slot wins
        script.push_back(with_answer(row_query(2'd3, 32'd0, 32'd0, 32'd0),
                                     2, 32'h1234_5678, 1'b0));
        // no axes from the query: every distance is zero
        script.push_back(with_answer(row_query(2'd0, 32'h8000_0000, 32'h8000_0000,
                                               32'h8000_0000), 0, 32'h7FFF_FFFF, 1'b0));
        script.push_back(row_query(2'd1, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF));
        script.push_back(row_query(2'd2, 32'h4000_0000, 32'hC000_0000, 32'd0));
        script.push_back(row_cfg(REG_POINT_DIM, 32'd1));
        script.push_back(row_query(2'd3, 32'hFFFF_FFF0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        // no axes stored: every distance is zero
        script.push_back(row_cfg(REG_POINT_DIM, 32'd0));
        script.push_back(with_answer(row_query(2'd3, 32'h8000_0000, 32'h8000_0000,
                                               32'h8000_0000), 0, 32'h7FFF_FFFF, 1'b0));
        script.push_back(row_cfg(REG_POINT_DIM, 32'd2));
        script.push_back(row_query(2'd3, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0));
        script.push_back(row_cfg(REG_POINT_COUNT, 32'd0));
        script.push_back(with_answer(row_query(2'd3, 32'd5, 32'd6, 32'd7), 0, 32'd0, 1'b1));
        script.push_back(row_cfg(REG_POINT_DIM, 32'd3));

        foreach (script[k]) begin
            if (script[k].is_cfg) begin
                cfg_write(script[k].cfg_reg, script[k].cfg_val);
            end else begin
                send_item(script[k].item, script[k].typed, script[k].answer);
            end
        end

        // Random phases, each with its own table size and axis count
        for (int ph = 0; ph < 10; ph++) begin
            cfg_write(REG_POINT_COUNT, 32'(cnt_list[ph]));
            cfg_write(REG_POINT_DIM, 32'(dim_list[ph]));
            // make sure every entry a query visits holds a point
            for (int e = 0; e < cnt_list[ph]; e++) begin
                if (!pt_loaded[e]) begin
                    send_item(rand_load(e), 1'b0, '0);
                end
            end
            repeat (50) begin
                // give the sender a stretch with no gaps at all
                sender_calm = (sent_random >= 250 && sent_random < 350);
                if (scan_ready() && $urandom_range(99) < 60) begin
                    send_item(rand_query(), 1'b0, '0);
                end else begin
                    send_item(rand_load(pick_slot()), 1'b0, '0);
                end
                sent_random++;
            end
        end

        // Drop valid, drain the answers owed, then let the pipeline go quiet
        in_valid <= 1'b0;
        while (hits_due.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE) @(posedge clk);

        if (mismatches == 0 && hits_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
